// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every rising edge outside reset
`define AYUV_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// ante implies cons in the same cycle
`define AYUV_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`else

`define AYUV_ASSERT(lbl, clk, rstn, prop, msg)
`define AYUV_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/ayuv_pkg.sv =====
// ---------------------------------------------------------------------------
// ayuv_pkg
// Constants, types and color conversion functions of the YUV 4:2:0 converter.
// ---------------------------------------------------------------------------
package ayuv_pkg;

  // Geometry
  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned PairDepth = MaxWidth / 2;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned AddrW     = $clog2(PairDepth);

  // Field widths
  localparam int unsigned PixW  = 8;
  localparam int unsigned SumW  = PixW + 1;
  localparam int unsigned CfgW  = 13;
  localparam int unsigned LineW = 2 * SumW;

  localparam logic [CfgW-1:0] LineWidthRst = CfgW'(640);
  localparam logic [CfgW-1:0] MinLineWidth = CfgW'(2);
  localparam logic [CfgW-1:0] MaxLineWidth = CfgW'(MaxWidth);

  // Luma coefficients, Q7
  localparam logic [14:0] CoefYR = 15'd27;
  localparam logic [14:0] CoefYG = 15'd91;
  localparam logic [14:0] CoefYB = 15'd9;

  // Chroma coefficients, Q7
  localparam logic signed [16:0] CoefUR = -17'sd12;
  localparam logic signed [16:0] CoefUG = -17'sd43;
  localparam logic signed [16:0] CoefUB = 17'sd55;
  localparam logic signed [16:0] CoefVR = 17'sd78;
  localparam logic signed [16:0] CoefVG = -17'sd71;
  localparam logic signed [16:0] CoefVB = -17'sd7;
  localparam logic signed [16:0] ChromaOfs = 17'sd127;
  localparam logic signed [16:0] PixMax    = 17'sd255;

  // Position of an item within the 2x2 quad
  typedef struct packed {
    logic             odd;
    logic             bottom;
    logic [AddrW-1:0] addr;
  } quad_pos_t;

  // Luma: sum stays below 2^15, so no clamp is needed after the shift
  function automatic logic [PixW-1:0] luma_f(input logic [PixW-1:0] r,
                                             input logic [PixW-1:0] g,
                                             input logic [PixW-1:0] b);
    logic [14:0] acc;
    acc = 15'(r) * CoefYR + 15'(g) * CoefYG + 15'(b) * CoefYB;
    return acc[14:7];
  endfunction

  // Floor shift, offset, clamp to 0..255
  function automatic logic [PixW-1:0] chroma_f(input logic [PixW-1:0] r,
                                               input logic [PixW-1:0] g,
                                               input logic [PixW-1:0] b,
                                               input logic signed [16:0] kr,
                                               input logic signed [16:0] kg,
                                               input logic signed [16:0] kb);
    logic signed [16:0] rs;
    logic signed [16:0] gs;
    logic signed [16:0] bs;
    logic signed [16:0] acc;
    logic signed [16:0] t;
    logic [PixW-1:0]    res;
    rs  = signed'({9'd0, r});
    gs  = signed'({9'd0, g});
    bs  = signed'({9'd0, b});
    acc = kr * rs + kg * gs + kb * bs;
    t   = (acc >>> 7) + ChromaOfs;
    if (t < 17'sd0) begin
      res = '0;
    end else if (t > PixMax) begin
      res = '1;
    end else begin
      res = t[PixW-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/ayuv_pix_if.sv =====
// ---------------------------------------------------------------------------
// ayuv_pix_if
// Input pixel channel: valid/ready handshake with RGB and frame start.
// ---------------------------------------------------------------------------
interface ayuv_pix_if;
  logic                        valid;
  logic                        ready;
  logic [ayuv_pkg::PixW-1:0]   red;
  logic [ayuv_pkg::PixW-1:0]   green;
  logic [ayuv_pkg::PixW-1:0]   blue;
  logic                        frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

// ===== rtl/ayuv_res_if.sv =====
// ---------------------------------------------------------------------------
// ayuv_res_if
// Result channel: valid/ready handshake with luma and averaged chroma.
// ---------------------------------------------------------------------------
interface ayuv_res_if;
  logic                        valid;
  logic                        ready;
  logic [ayuv_pkg::PixW-1:0]   luma;
  logic [ayuv_pkg::PixW-1:0]   chroma_u;
  logic [ayuv_pkg::PixW-1:0]   chroma_v;
  logic                        chroma_valid;

  modport source (output valid, luma, chroma_u, chroma_v, chroma_valid, input ready);
  modport sink   (input valid, luma, chroma_u, chroma_v, chroma_valid, output ready);
endinterface

// ===== rtl/ayuv_ram.sv =====
// ---------------------------------------------------------------------------
// ayuv_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module ayuv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds when no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/argb_to_yuv420_converter.sv =====
// ---------------------------------------------------------------------------
// argb_to_yuv420_converter
// RGB raster stream to Y per pixel plus 2x2 averaged U/V on odd rows.
// ---------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  pix_i     in   valid / ready     red, green, blue, frame_start
//  res_o     out  valid / ready     luma, chroma_u, chroma_v, chroma_valid
//  cfg       in   cfg_we_i          cfg_wdata_i = line_width (13 bits)
//
//  One pixel per clock while res_o is not back-pressured; a taken pixel is
//  registered in stage 1 (line buffer read), then in the output register.
//  Top-row pair sums live in one 2048 x 18 RAM, read at accept of a
//  bottom-row odd pixel, written when a top-row odd pixel leaves stage 1.
//  No clearing pass: the line buffer is undefined until a top row fills it.
//  A stalled output holds stage 1 and the RAM read data in place.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module argb_to_yuv420_converter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ayuv_pix_if.sink                      pix_i,
  ayuv_res_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [ayuv_pkg::CfgW-1:0]     cfg_wdata_i
);

  localparam int unsigned ColW  = ayuv_pkg::ColW;
  localparam int unsigned AddrW = ayuv_pkg::AddrW;
  localparam int unsigned CfgW  = ayuv_pkg::CfgW;
  localparam int unsigned PixW  = ayuv_pkg::PixW;
  localparam int unsigned SumW  = ayuv_pkg::SumW;

  // Configuration register
  logic [CfgW-1:0] line_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= ayuv_pkg::LineWidthRst;
    end else if (cfg_we_i) begin
      line_width_q <= cfg_wdata_i;
    end
  end

  // Effective width: even, saturated to the buffer range
  logic [CfgW-1:0] lw_even;
  logic [CfgW-1:0] eff_width;

  always_comb begin
    lw_even = {line_width_q[CfgW-1:1], 1'b0};
    if (lw_even < ayuv_pkg::MinLineWidth) begin
      eff_width = ayuv_pkg::MinLineWidth;
    end else if (lw_even > ayuv_pkg::MaxLineWidth) begin
      eff_width = ayuv_pkg::MaxLineWidth;
    end else begin
      eff_width = lw_even;
    end
  end

  // Handshake and pipeline advance
  logic pix_fire;
  logic s1_valid_q;
  logic s1_fire;
  logic out_valid_q;

  assign s1_fire     = s1_valid_q && (!out_valid_q || res_o.ready);
  assign pix_i.ready = !s1_valid_q || !out_valid_q || res_o.ready;
  assign pix_fire    = pix_i.valid && pix_i.ready;

  // Raster position
  logic [ColW-1:0] col_q;
  logic            bottom_q;
  logic [ColW-1:0] col_cur;
  logic            bottom_cur;
  logic            row_last;

  always_comb begin
    col_cur    = pix_i.frame_start ? '0 : col_q;
    bottom_cur = pix_i.frame_start ? 1'b0 : bottom_q;
    row_last   = (CfgW'(col_cur) + CfgW'(1)) >= eff_width;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      bottom_q <= 1'b0;
    end else if (pix_fire) begin
      col_q    <= row_last ? '0 : col_cur + ColW'(1);
      bottom_q <= row_last ? !bottom_cur : bottom_cur;
    end
  end

  // Stage 1: pixel and quad position
  logic [PixW-1:0]     s1_red_q;
  logic [PixW-1:0]     s1_green_q;
  logic [PixW-1:0]     s1_blue_q;
  ayuv_pkg::quad_pos_t s1_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      s1_red_q        <= pix_i.red;
      s1_green_q      <= pix_i.green;
      s1_blue_q       <= pix_i.blue;
      s1_pos_q.odd    <= col_cur[0];
      s1_pos_q.bottom <= bottom_cur;
      s1_pos_q.addr   <= col_cur[ColW-1:1];
    end
  end

  // Line buffer of top-row pair sums {u_sum, v_sum}
  logic                  ram_re;
  logic [AddrW-1:0]      ram_raddr;
  logic                  ram_we;
  logic [2*SumW-1:0]     ram_wdata;
  logic [2*SumW-1:0]     ram_rdata;

  assign ram_re    = pix_fire && col_cur[0] && bottom_cur;
  assign ram_raddr = col_cur[ColW-1:1];
  assign ram_we    = s1_fire && s1_pos_q.odd && !s1_pos_q.bottom;

  ayuv_ram #(
    .Width (2 * SumW),
    .Depth (ayuv_pkg::PairDepth)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_pos_q.addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Color conversion of the stage 1 pixel
  logic [PixW-1:0] y_s1;
  logic [PixW-1:0] u_s1;
  logic [PixW-1:0] v_s1;

  always_comb begin
    y_s1 = ayuv_pkg::luma_f(s1_red_q, s1_green_q, s1_blue_q);
    u_s1 = ayuv_pkg::chroma_f(s1_red_q, s1_green_q, s1_blue_q,
                              ayuv_pkg::CoefUR, ayuv_pkg::CoefUG, ayuv_pkg::CoefUB);
    v_s1 = ayuv_pkg::chroma_f(s1_red_q, s1_green_q, s1_blue_q,
                              ayuv_pkg::CoefVR, ayuv_pkg::CoefVG, ayuv_pkg::CoefVB);
  end

  // Pair sums and quad mean
  logic [PixW-1:0] pend_u_q;
  logic [PixW-1:0] pend_v_q;
  logic [SumW-1:0] pair_u;
  logic [SumW-1:0] pair_v;
  logic [SumW:0]   quad_u;
  logic [SumW:0]   quad_v;

  always_comb begin
    pair_u    = SumW'(pend_u_q) + SumW'(u_s1);
    pair_v    = SumW'(pend_v_q) + SumW'(v_s1);
    ram_wdata = {pair_u, pair_v};
    quad_u    = (SumW+1)'(ram_rdata[2*SumW-1:SumW]) + (SumW+1)'(pair_u);
    quad_v    = (SumW+1)'(ram_rdata[SumW-1:0]) + (SumW+1)'(pair_v);
  end

  // Even-column chroma waits for its pair partner
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_u_q <= '0;
      pend_v_q <= '0;
    end else if (s1_fire && !s1_pos_q.odd) begin
      pend_u_q <= u_s1;
      pend_v_q <= v_s1;
    end
  end

  // Output register
  logic [PixW-1:0] out_luma_q;
  logic [PixW-1:0] out_u_q;
  logic [PixW-1:0] out_v_q;
  logic            out_cvalid_q;
  logic            quad_done;

  assign quad_done = s1_pos_q.odd && s1_pos_q.bottom;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_luma_q   <= y_s1;
      out_u_q      <= quad_done ? quad_u[SumW:2] : '0;
      out_v_q      <= quad_done ? quad_v[SumW:2] : '0;
      out_cvalid_q <= quad_done;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.luma         = out_luma_q;
  assign res_o.chroma_u     = out_u_q;
  assign res_o.chroma_v     = out_v_q;
  assign res_o.chroma_valid = out_cvalid_q;

  // Checks
  // a bottom-row read never meets a top-row write to the same pair
  `AYUV_ASSERT_IMPL(a_no_rw_clash, clk_i, rst_ni, ram_re && ram_we, ram_raddr != s1_pos_q.addr, "line buffer read and write hit the same entry")
  // chroma fields are zero unless a quad completes
  `AYUV_ASSERT_IMPL(a_chroma_zero, clk_i, rst_ni, res_o.valid && !res_o.chroma_valid, res_o.chroma_u == '0 && res_o.chroma_v == '0, "chroma not zero outside a quad")

endmodule
